FILE: hw/rtl/krs_pkg.sv
// types, constants and codes shared by the keypad row scanner files
package krs_pkg;

  // build constants
  localparam int unsigned MaxRows   = 4;
  localparam int unsigned TimeBits  = 32;
  localparam int unsigned MinRows   = 3;

  // fixed field widths
  localparam int unsigned RowLevelW = 4;
  localparam int unsigned PhaseW    = 3;
  localparam int unsigned CodeW     = 8;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned TimeoutW  = 16;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [PhaseW-1:0]   RowCountReset = PhaseW'(MaxRows);
  localparam logic [TimeoutW-1:0] TimeoutReset  = TimeoutW'(1000);

  // item operation
  typedef enum logic [0:0] {
    OP_SCAN = 1'b0,
    OP_READ = 1'b1
  } op_e;

  // key event mode
  typedef enum logic [1:0] {
    MODE_NONE     = 2'd0,
    MODE_PRESSED  = 2'd1,
    MODE_RELEASED = 2'd2,
    MODE_LONG     = 2'd3
  } mode_e;

  // configuration register index
  typedef enum logic [0:0] {
    CFG_ROW_COUNT    = 1'b0,
    CFG_LONG_TIMEOUT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    op_e                  operation;
    logic [RowLevelW-1:0] row_levels;
    logic [TimeW-1:0]     time_ms;
  } in_item_t;

  typedef struct packed {
    logic [PhaseW-1:0] drive_row;
    logic              event_pending;
    mode_e             event_mode;
    logic [CodeW-1:0]  read_code;
  } out_item_t;

endpackage

FILE: hw/rtl/krs_if.sv
// handshake channel interfaces for scan items and result items
interface krs_in_if;
  logic              valid;
  logic              ready;
  krs_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface krs_out_if;
  logic               valid;
  logic               ready;
  krs_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: hw/rtl/keypad_row_scan_event_detector.sv
// keypad row scanner with press, release and long press event detection
//
// Usage: each input item is either a scan step (operation scan) carrying the
// active-low row levels sampled for the row named by the last drive_row, plus
// the millisecond time, or a read (operation read) that returns the key code
// and clears the pending event. Every item yields exactly one result item with
// the row to drive next, the pending flag, the event mode and, on reads, the
// code. Configuration (row count, long press timeout) is written through the
// cfg_* port; the user must do so only while no item is in flight, since the
// block does not enforce it. An accepted item waits in the input register,
// and its result is then written to the result register. Items are taken at
// one item per cycle while the receiver does not stall: an input register feeds a
// single step of compare and select logic that updates the scan state and the
// result register together.
// Reset clears the scan state, pending flag and mode, sets row count to the
// maximum and the timeout to 1000 ms; both channels come up empty.
// When the receiver stalls the result is held, the input register holds the
// next item, and in_i.ready drops once both stages are full.
module keypad_row_scan_event_detector (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  krs_in_if.sink                         in_i,
  krs_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  krs_pkg::cfg_reg_e              cfg_index_i,
  input  logic [krs_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  // configuration registers
  logic [krs_pkg::PhaseW-1:0]   row_count_q;
  logic [krs_pkg::TimeoutW-1:0] timeout_q;

  // pipeline registers
  logic               in_valid_q;
  krs_pkg::in_item_t  in_q;
  logic               out_valid_q;
  krs_pkg::out_item_t out_q;

  // scan and event state
  logic [krs_pkg::PhaseW-1:0]   phase_q, phase_d;
  logic [krs_pkg::CodeW-1:0]    first_q, first_d;
  logic [krs_pkg::CodeW-1:0]    cur_q, cur_d;
  logic [krs_pkg::CodeW-1:0]    prev_q, prev_d;
  logic [krs_pkg::CodeW-1:0]    rel_q, rel_d;
  logic                         pend_q, pend_d;
  krs_pkg::mode_e               mode_q, mode_d;
  logic [krs_pkg::TimeBits-1:0] chg_q, chg_d;

  krs_pkg::out_item_t res;
  logic               adv;
  logic               fire;

  // handshake
  assign adv         = !out_valid_q || out_o.ready;
  assign fire        = in_valid_q && adv;
  assign in_i.ready  = !in_valid_q || adv;
  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_q;

  // configuration writes, row count clamped to the supported range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= krs_pkg::RowCountReset;
      timeout_q   <= krs_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        krs_pkg::CFG_ROW_COUNT: begin
          if (cfg_wdata_i[krs_pkg::PhaseW-1:0] < krs_pkg::PhaseW'(krs_pkg::MinRows)) begin
            row_count_q <= krs_pkg::PhaseW'(krs_pkg::MinRows);
          end else if (cfg_wdata_i[krs_pkg::PhaseW-1:0] >
                       krs_pkg::PhaseW'(krs_pkg::MaxRows)) begin
            row_count_q <= krs_pkg::PhaseW'(krs_pkg::MaxRows);
          end else begin
            row_count_q <= cfg_wdata_i[krs_pkg::PhaseW-1:0];
          end
        end
        krs_pkg::CFG_LONG_TIMEOUT: begin
          timeout_q <= cfg_wdata_i[krs_pkg::TimeoutW-1:0];
        end
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.item;
    end
  end

  // read handling, scan step and end of sweep event detection
  always_comb begin
    logic [krs_pkg::RowLevelW-1:0] row_mask;
    logic [krs_pkg::RowLevelW-1:0] bits;
    logic [krs_pkg::CodeW-1:0]     code;
    logic [krs_pkg::CodeW-1:0]     idle_code;
    logic [krs_pkg::PhaseW-1:0]    nxt_phase;
    logic [krs_pkg::TimeBits-1:0]  now;
    logic [krs_pkg::TimeBits-1:0]  elapsed;

    phase_d   = phase_q;
    first_d   = first_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    rel_d     = rel_q;
    pend_d    = pend_q;
    mode_d    = mode_q;
    chg_d     = chg_q;
    res       = '0;
    row_mask  = '0;
    bits      = '0;
    code      = '0;
    idle_code = '0;
    nxt_phase = '0;
    now       = in_q.time_ms[krs_pkg::TimeBits-1:0];
    elapsed   = now - chg_q;

    if (in_q.operation == krs_pkg::OP_READ) begin
      res.read_code = (mode_q == krs_pkg::MODE_RELEASED) ? rel_q : cur_q;
      pend_d        = 1'b0;
    end else begin
      // active rows only, driven row masked off
      for (int i = 0; i < krs_pkg::RowLevelW; i++) begin
        row_mask[i] = (krs_pkg::PhaseW'(i) < row_count_q);
      end
      bits = ~in_q.row_levels & row_mask & ~(krs_pkg::RowLevelW'(1) << phase_q);
      code = (krs_pkg::CodeW'(bits) << phase_q) + krs_pkg::CodeW'(phase_q);

      if (bits != '0 && phase_q == row_count_q) begin
        idle_code = code;
      end else if (bits != '0 && first_q == '0) begin
        first_d = code;
      end

      nxt_phase = phase_q + krs_pkg::PhaseW'(1);
      if (nxt_phase > row_count_q) begin
        phase_d = '0;
        cur_d   = (idle_code != '0) ? idle_code : first_d;
        first_d = '0;

        if (prev_q != cur_d && !pend_q) begin
          priority if (prev_q == '0 && cur_d != '0) begin
            mode_d = krs_pkg::MODE_PRESSED;
          end else if (cur_d == '0 && prev_q != '0) begin
            mode_d = krs_pkg::MODE_RELEASED;
          end else begin
            mode_d = krs_pkg::MODE_NONE;
          end
          if (mode_d != krs_pkg::MODE_NONE) begin
            rel_d  = (mode_d == krs_pkg::MODE_RELEASED) ? prev_q : '0;
            pend_d = 1'b1;
            prev_d = cur_d;
            chg_d  = now;
          end
        end else if (cur_d != '0 && prev_q == cur_d && !pend_q &&
                     mode_q != krs_pkg::MODE_LONG &&
                     elapsed > krs_pkg::TimeBits'(timeout_q)) begin
          mode_d = krs_pkg::MODE_LONG;
          pend_d = 1'b1;
        end
      end else begin
        phase_d = nxt_phase;
      end
    end

    res.drive_row     = phase_d;
    res.event_pending = pend_d;
    res.event_mode    = mode_d;
  end

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      first_q <= '0;
      cur_q   <= '0;
      prev_q  <= '0;
      rel_q   <= '0;
      pend_q  <= 1'b0;
      mode_q  <= krs_pkg::MODE_NONE;
      chg_q   <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      first_q <= first_d;
      cur_q   <= cur_d;
      prev_q  <= prev_d;
      rel_q   <= rel_d;
      pend_q  <= pend_d;
      mode_q  <= mode_d;
      chg_q   <= chg_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  // checks
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= krs_pkg::PhaseW'(krs_pkg::MaxRows))
    else $error("scan phase beyond the last row");

  a_row_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_count_q >= krs_pkg::PhaseW'(krs_pkg::MinRows) &&
    row_count_q <= krs_pkg::PhaseW'(krs_pkg::MaxRows))
    else $error("row count outside supported range");

  a_pending_has_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pend_q) |-> mode_q != krs_pkg::MODE_NONE)
    else $error("event raised with no mode");

  a_released_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == krs_pkg::MODE_RELEASED |-> rel_q != '0)
    else $error("release event without a released code");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_q))
    else $error("buffered item lost while the result stage is stalled");

endmodule
